// ===== rtl/assert_macros.svh =====
// assertion macros for the sensor sequencer rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_HOLDS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// expression must never be true outside reset
`define AST_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== rtl/hts_pkg.sv =====
// shared types and constants for the humidity/temperature sensor sequencer
// no dependencies
package hts_pkg;

	localparam logic [2:0] CMD_NONE      = 3'd0;
	localparam logic [2:0] CMD_START     = 3'd1;
	localparam logic [2:0] CMD_WRITE     = 3'd2;
	localparam logic [2:0] CMD_READ_ACK  = 3'd3;
	localparam logic [2:0] CMD_READ_NACK = 3'd4;
	localparam logic [2:0] CMD_STOP      = 3'd5;
	localparam logic [2:0] CMD_WAIT      = 3'd6;

	localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [1:0] REG_DEVICE_ADDR   = 2'd1;
	localparam logic [1:0] REG_HUM_WAIT      = 2'd2;
	localparam logic [1:0] REG_TEMP_WAIT     = 2'd3;

	localparam logic [7:0] RST_SAMPLE_PERIOD = 8'd10;
	localparam logic [6:0] RST_DEVICE_ADDR   = 7'd64;
	localparam logic [7:0] RST_HUM_WAIT      = 8'd20;
	localparam logic [7:0] RST_TEMP_WAIT     = 8'd60;

	localparam logic [7:0] SNS_HUM_MEAS   = 8'he5;
	localparam logic [7:0] SNS_TEMP_MEAS  = 8'he3;
	localparam logic [7:0] SNS_READ_USER  = 8'he7;
	localparam logic [7:0] SNS_WRITE_USER = 8'he6;
	localparam logic [7:0] SNS_SOFT_RESET = 8'hfe;
	localparam logic [7:0] USER_KEEP_MASK = 8'h38;
	localparam logic [7:0] USER_SET_BITS  = 8'h02;

	localparam logic [7:0] WAIT_INIT_MS  = 8'd10;
	localparam logic [7:0] WAIT_RST1_MS  = 8'd15;
	localparam logic [7:0] WAIT_RST2_MS  = 8'd100;
	localparam logic [7:0] WAIT_GAP_MS   = 8'd10;

	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 48;

	typedef struct packed {
		logic [2:0]         bus_command;
		logic [7:0]         tx_byte;
		logic [7:0]         wait_ms;
		logic [10:0]        humidity_x10;
		logic signed [11:0] temperature_x10;
		logic               new_reading;
		logic               failed;
	} hts_res_t;

endpackage

// ===== rtl/hts_conv.sv =====
// raw sensor word to humidity and temperature in tenths
// uses hts_pkg; one multiply registered per path, final scaling on the registered value
module hts_conv
	import hts_pkg::*;
(
	input  logic               clk,
	input  logic [15:0]        raw_next,
	output logic [10:0]        humidity_x10,
	output logic signed [11:0] temperature_x10
);

	logic [15:0]        raw_v;
	logic [22:0]        prod_h;
	logic [30:0]        prod_t;
	logic signed [31:0] n_t;
	logic [31:0]        mag_t;
	logic [6:0]         hq_q;
	logic [13:0]        tmag_q;
	logic               tneg_q;
	logic [6:0]         hd;
	logic [29:0]        prod_d;
	logic [10:0]        tq;

	assign raw_v  = {raw_next[15:2], 2'b00};
	assign prod_h = 23'(raw_v) * 23'd125;
	assign prod_t = 31'(raw_v) * 31'd17572;
	assign n_t    = $signed({1'b0, prod_t}) - 32'sd307036160;
	assign mag_t  = n_t[31] ? 32'(-n_t) : 32'(n_t);

	always_ff @(posedge clk) begin
		hq_q   <= prod_h[22:16];
		tmag_q <= mag_t[29:16];
		tneg_q <= n_t[31];
	end

	// humidity: (q - 6) * 10, floored at zero
	assign hd = hq_q - 7'd6;
	assign humidity_x10 = (hq_q >= 7'd6) ? ({1'b0, hd, 3'b000} + {3'b000, hd, 1'b0}) : 11'd0;

	// divide by ten via reciprocal
	assign prod_d = 30'(tmag_q) * 30'd52429;
	assign tq     = prod_d[29:19];
	assign temperature_x10 = tneg_q ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

endmodule

// ===== rtl/hts_seq.sv =====
// command sequencer state, configuration registers and per-beat step logic
// uses hts_pkg; takes converted readings from hts_conv
module hts_seq
	import hts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               step_en,
	input  logic               op,
	input  logic               ack_seen,
	input  logic [7:0]         rx_byte,
	input  logic [10:0]        hum_conv,
	input  logic signed [11:0] temp_conv,
	output logic [15:0]        raw_next,
	output hts_res_t           res
);

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] I_START1  = 6'd1;
	localparam logic [5:0] I_ADDRW1  = 6'd2;
	localparam logic [5:0] I_RDSR    = 6'd3;
	localparam logic [5:0] I_START2  = 6'd4;
	localparam logic [5:0] I_ADDRR   = 6'd5;
	localparam logic [5:0] I_READ    = 6'd6;
	localparam logic [5:0] I_START3  = 6'd7;
	localparam logic [5:0] I_ADDRW2  = 6'd8;
	localparam logic [5:0] I_WRSR    = 6'd9;
	localparam logic [5:0] I_VAL     = 6'd10;
	localparam logic [5:0] I_STOP    = 6'd11;
	localparam logic [5:0] I_WAIT    = 6'd12;
	localparam logic [5:0] R_START   = 6'd13;
	localparam logic [5:0] R_ADDRW   = 6'd14;
	localparam logic [5:0] R_CMD     = 6'd15;
	localparam logic [5:0] R_STOP    = 6'd16;
	localparam logic [5:0] R_WAIT15  = 6'd17;
	localparam logic [5:0] R_WAIT100 = 6'd18;
	localparam logic [5:0] M_START1  = 6'd19;
	localparam logic [5:0] M_ADDRW1  = 6'd20;
	localparam logic [5:0] M_HCMD    = 6'd21;
	localparam logic [5:0] M_START2  = 6'd22;
	localparam logic [5:0] M_ADDRR1  = 6'd23;
	localparam logic [5:0] M_WAITH   = 6'd24;
	localparam logic [5:0] M_RDH1    = 6'd25;
	localparam logic [5:0] M_RDH2    = 6'd26;
	localparam logic [5:0] M_STOPH   = 6'd27;
	localparam logic [5:0] M_GAP     = 6'd28;
	localparam logic [5:0] M_START3  = 6'd29;
	localparam logic [5:0] M_ADDRW2  = 6'd30;
	localparam logic [5:0] M_TCMD    = 6'd31;
	localparam logic [5:0] M_START4  = 6'd32;
	localparam logic [5:0] M_ADDRR2  = 6'd33;
	localparam logic [5:0] M_WAITT   = 6'd34;
	localparam logic [5:0] M_RDT1    = 6'd35;
	localparam logic [5:0] M_RDT2    = 6'd36;
	localparam logic [5:0] M_STOPT   = 6'd37;

	logic [7:0]         period_q, hwait_q, twait_q;
	logic [6:0]         addr_q;
	logic [5:0]         step_q, step_d;
	logic [7:0]         tick_q, tick_d, tick_inc;
	logic               fail_q, fail_d;
	logic               pend_q, pend_d;
	logic [7:0]         ureg_q, ureg_d;
	logic [15:0]        raw_q, raw_d;
	logic [10:0]        hum_q, hum_d;
	logic signed [11:0] temp_q, temp_d;
	logic [7:0]         addr_wr, addr_rd;
	logic               do_finish;

	function automatic logic is_write(input logic [5:0] s);
		return s == I_ADDRW1 || s == I_RDSR || s == I_ADDRR || s == I_ADDRW2 ||
			s == I_WRSR || s == I_VAL || s == R_ADDRW || s == R_CMD ||
			s == M_ADDRW1 || s == M_HCMD || s == M_ADDRR1 || s == M_ADDRW2 ||
			s == M_TCMD || s == M_ADDRR2;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RST_SAMPLE_PERIOD;
			addr_q   <= RST_DEVICE_ADDR;
			hwait_q  <= RST_HUM_WAIT;
			twait_q  <= RST_TEMP_WAIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_PERIOD: period_q <= cfg_data;
				REG_DEVICE_ADDR:   addr_q   <= cfg_data[6:0];
				REG_HUM_WAIT:      hwait_q  <= cfg_data;
				REG_TEMP_WAIT:     twait_q  <= cfg_data;
				default:           period_q <= period_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			tick_q <= 8'd0;
			fail_q <= 1'b1;
			pend_q <= 1'b0;
			ureg_q <= 8'd0;
			raw_q  <= 16'd0;
			hum_q  <= 11'd0;
			temp_q <= 12'sd0;
		end else begin
			step_q <= step_d;
			tick_q <= tick_d;
			fail_q <= fail_d;
			pend_q <= pend_d;
			ureg_q <= ureg_d;
			raw_q  <= raw_d;
			hum_q  <= hum_d;
			temp_q <= temp_d;
		end
	end

	assign addr_wr  = {addr_q, 1'b0};
	assign addr_rd  = {addr_q, 1'b1};
	assign tick_inc = tick_q + 8'd1;
	assign raw_next = raw_d;

	always_comb begin
		step_d    = step_q;
		tick_d    = tick_q;
		fail_d    = fail_q;
		pend_d    = pend_q;
		ureg_d    = ureg_q;
		raw_d     = raw_q;
		hum_d     = hum_q;
		temp_d    = temp_q;
		do_finish = 1'b0;
		res.bus_command = CMD_NONE;
		res.tx_byte     = 8'd0;
		res.wait_ms     = 8'd0;
		res.new_reading = 1'b0;
		if (step_en) begin
			if (op) begin
				if (step_q != S_IDLE) begin
					if (is_write(step_q) && !ack_seen) begin
						fail_d = 1'b1;
						if (step_q < R_START) begin
							do_finish = 1'b1;
						end else if (step_q < M_START1) begin
							res.bus_command = CMD_WAIT;
							res.wait_ms     = WAIT_RST2_MS;
							step_d          = R_WAIT100;
						end else begin
							hum_d     = 11'd0;
							temp_d    = 12'sd0;
							do_finish = 1'b1;
						end
					end else begin
						case (step_q)
							I_START1: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_wr; step_d = I_ADDRW1;
							end
							I_ADDRW1: begin
								res.bus_command = CMD_WRITE; res.tx_byte = SNS_READ_USER;
								step_d = I_RDSR;
							end
							I_RDSR: begin
								res.bus_command = CMD_START; step_d = I_START2;
							end
							I_START2: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_rd; step_d = I_ADDRR;
							end
							I_ADDRR: begin
								res.bus_command = CMD_READ_NACK; step_d = I_READ;
							end
							I_READ: begin
								ureg_d = rx_byte; res.bus_command = CMD_START; step_d = I_START3;
							end
							I_START3: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_wr; step_d = I_ADDRW2;
							end
							I_ADDRW2: begin
								res.bus_command = CMD_WRITE; res.tx_byte = SNS_WRITE_USER;
								step_d = I_WRSR;
							end
							I_WRSR: begin
								res.bus_command = CMD_WRITE;
								res.tx_byte     = (ureg_q & USER_KEEP_MASK) | USER_SET_BITS;
								step_d          = I_VAL;
							end
							I_VAL: begin
								res.bus_command = CMD_STOP; step_d = I_STOP;
							end
							I_STOP: begin
								fail_d = 1'b0; res.bus_command = CMD_WAIT;
								res.wait_ms = WAIT_INIT_MS; step_d = I_WAIT;
							end
							I_WAIT: begin
								res.bus_command = CMD_START; step_d = R_START;
							end
							R_START: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_wr; step_d = R_ADDRW;
							end
							R_ADDRW: begin
								res.bus_command = CMD_WRITE; res.tx_byte = SNS_SOFT_RESET;
								step_d = R_CMD;
							end
							R_CMD: begin
								res.bus_command = CMD_STOP; step_d = R_STOP;
							end
							R_STOP: begin
								res.bus_command = CMD_WAIT; res.wait_ms = WAIT_RST1_MS;
								step_d = R_WAIT15;
							end
							R_WAIT15: begin
								fail_d = 1'b0; res.bus_command = CMD_WAIT;
								res.wait_ms = WAIT_RST2_MS; step_d = R_WAIT100;
							end
							R_WAIT100: begin
								res.bus_command = CMD_START; step_d = M_START1;
							end
							M_START1: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_wr; step_d = M_ADDRW1;
							end
							M_ADDRW1: begin
								res.bus_command = CMD_WRITE; res.tx_byte = SNS_HUM_MEAS;
								step_d = M_HCMD;
							end
							M_HCMD: begin
								res.bus_command = CMD_START; step_d = M_START2;
							end
							M_START2: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_rd; step_d = M_ADDRR1;
							end
							M_ADDRR1: begin
								res.bus_command = CMD_WAIT; res.wait_ms = hwait_q; step_d = M_WAITH;
							end
							M_WAITH: begin
								res.bus_command = CMD_READ_ACK; step_d = M_RDH1;
							end
							M_RDH1: begin
								raw_d = {rx_byte, 8'd0}; res.bus_command = CMD_READ_NACK;
								step_d = M_RDH2;
							end
							M_RDH2: begin
								raw_d = {raw_q[15:8], raw_q[7:0] | rx_byte};
								res.bus_command = CMD_STOP; step_d = M_STOPH;
							end
							M_STOPH: begin
								hum_d = hum_conv; res.bus_command = CMD_WAIT;
								res.wait_ms = WAIT_GAP_MS; step_d = M_GAP;
							end
							M_GAP: begin
								res.bus_command = CMD_START; step_d = M_START3;
							end
							M_START3: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_wr; step_d = M_ADDRW2;
							end
							M_ADDRW2: begin
								res.bus_command = CMD_WRITE; res.tx_byte = SNS_TEMP_MEAS;
								step_d = M_TCMD;
							end
							M_TCMD: begin
								res.bus_command = CMD_START; step_d = M_START4;
							end
							M_START4: begin
								res.bus_command = CMD_WRITE; res.tx_byte = addr_rd; step_d = M_ADDRR2;
							end
							M_ADDRR2: begin
								res.bus_command = CMD_WAIT; res.wait_ms = twait_q; step_d = M_WAITT;
							end
							M_WAITT: begin
								res.bus_command = CMD_READ_ACK; step_d = M_RDT1;
							end
							M_RDT1: begin
								raw_d = {rx_byte, 8'd0}; res.bus_command = CMD_READ_NACK;
								step_d = M_RDT2;
							end
							M_RDT2: begin
								raw_d = {raw_q[15:8], raw_q[7:0] | rx_byte};
								res.bus_command = CMD_STOP; step_d = M_STOPT;
							end
							M_STOPT: begin
								temp_d          = temp_conv;
								fail_d          = 1'b0;
								res.new_reading = 1'b1;
								do_finish       = 1'b1;
							end
							default: begin
								step_d = S_IDLE;
							end
						endcase
					end
				end
			end else if (step_q == S_IDLE) begin
				if (fail_q) begin
					fail_d = 1'b0;
					res.bus_command = CMD_START;
					step_d = I_START1;
					if (8'd1 >= period_q) begin
						tick_d = 8'd0;
						pend_d = 1'b1;
					end else begin
						tick_d = 8'd1;
						pend_d = 1'b0;
					end
				end else if (tick_inc >= period_q) begin
					tick_d = 8'd0;
					res.bus_command = CMD_START;
					step_d = M_START1;
				end else begin
					tick_d = tick_inc;
				end
			end
		end
		if (do_finish) begin
			if (pend_q) begin
				pend_d = 1'b0;
				res.bus_command = CMD_START;
				step_d = M_START1;
			end else begin
				res.bus_command = CMD_NONE;
				step_d = S_IDLE;
			end
		end
		res.humidity_x10    = hum_d;
		res.temperature_x10 = temp_d;
		res.failed          = fail_d;
	end

endmodule

// ===== rtl/humidity_temp_sensor_sequencer_core.sv =====
// top level of the humidity/temperature sensor command sequencer
// uses hts_pkg, hts_seq, hts_conv and assert_macros.svh
//
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tuser: op; s_tdata: ack_seen, rx_byte
// m_*       out  m_tvalid / m_tready   m_tdata: command, tx, wait, readings, flags
// cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat in gives one beat out in the cycle after it, at one beat per cycle while m_tready keeps up
// the step logic sits between the input beat and the output register
// s_tready stays high while the output register is empty or being drained
// cfg_ready is always high; writes land at the clock edge of the beat
// reset clears the sequencer to idle with the fail flag set
`include "assert_macros.svh"

module humidity_temp_sensor_sequencer_core
	import hts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // ack_seen, rx_byte, zero pad
	input  logic                   s_tuser,   // op
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // bus_command, tx_byte, wait_ms,
	                                          // humidity_x10, temperature_x10,
	                                          // new_reading, failed, zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data
);

	logic               in_beat;
	logic [15:0]        raw_next;
	logic [10:0]        hum_conv;
	logic signed [11:0] temp_conv;
	hts_res_t           res;
	hts_res_t           out_q;
	logic               out_vld_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_vld_q || m_tready;
	assign in_beat   = s_tvalid && s_tready;

	hts_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (in_beat),
		.op        (s_tuser),
		.ack_seen  (s_tdata[0]),
		.rx_byte   (s_tdata[8:1]),
		.hum_conv  (hum_conv),
		.temp_conv (temp_conv),
		.raw_next  (raw_next),
		.res       (res)
	);

	hts_conv u_conv (
		.clk             (clk),
		.raw_next        (raw_next),
		.humidity_x10    (hum_conv),
		.temperature_x10 (temp_conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_beat) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_q.failed, out_q.new_reading, out_q.temperature_x10,
		out_q.humidity_x10, out_q.wait_ms, out_q.tx_byte, out_q.bus_command};

	`AST_HOLDS(a_beat_gives_result, in_beat |=> m_tvalid)
	`AST_NEVER(a_new_while_failed, m_tvalid && out_q.new_reading && out_q.failed)
	`AST_NEVER(a_new_with_bus_op, m_tvalid && out_q.new_reading && out_q.bus_command != CMD_NONE && out_q.bus_command != CMD_START)

endmodule

// ===== sim/tb.sv =====
// testbench for humidity_temp_sensor_sequencer_core: plays the byte-level bus master,
// feeding ticks and command completions and checking every command beat against a predictor
// depends on hts_pkg and the sequencer core rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hts_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_LEN    = 150;

	typedef enum logic [5:0] {
		SQ_IDLE,
		IN_START1, IN_ADDR_WR1, IN_READ_REG_CMD, IN_START2, IN_ADDR_RD, IN_READ,
		IN_START3, IN_ADDR_WR2, IN_WRITE_REG_CMD, IN_VALUE, IN_STOP, IN_WAIT,
		SR_START, SR_ADDR_WR, SR_CMD, SR_STOP, SR_WAIT15, SR_WAIT100,
		MS_START1, MS_ADDR_WR1, MS_HUM_CMD, MS_START2, MS_ADDR_RD1, MS_WAIT_HUM,
		MS_RD_HUM1, MS_RD_HUM2, MS_STOP_HUM, MS_GAP, MS_START3, MS_ADDR_WR2,
		MS_TEMP_CMD, MS_START4, MS_ADDR_RD2, MS_WAIT_TEMP, MS_RD_TEMP1, MS_RD_TEMP2,
		MS_STOP_TEMP
	} seq_step_e;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [7:0]         tx;
		logic [7:0]         ms;
		logic [10:0]        hum;
		logic signed [11:0] temp;
		logic               fresh;
		logic               failed;
	} cmd_beat_t;

	typedef struct packed {
		logic       op;
		logic       ack;
		logic [7:0] rx;
		logic       typed;
		logic [2:0] cmd;
		logic [7:0] tx;
		logic [7:0] ms;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;   // ack_seen, rx_byte, zero pad
	logic                   s_tuser = 1'b0; // op
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;        // bus_command, tx_byte, wait_ms, humidity_x10,
	                                        // temperature_x10, new_reading, failed, zero pad
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = '0;
	logic [7:0]             cfg_data = '0;

	humidity_temp_sensor_sequencer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0]         cfg_period;
	logic [6:0]         cfg_addr;
	logic [7:0]         cfg_hum_wait;
	logic [7:0]         cfg_temp_wait;
	seq_step_e          step;
	logic [2:0]         last_cmd;
	logic [7:0]         ticks;
	logic               fail_flag;
	logic               meas_queued;
	logic [15:0]        raw;
	logic [7:0]         user_copy;
	logic [10:0]        hum;
	logic signed [11:0] temp;
	logic [2:0]         o_cmd;
	logic [7:0]         o_tx;
	logic [7:0]         o_ms;
	logic               o_fresh;

	cmd_beat_t cmd_beats_due[$];
	int        mismatches = 0;
	int        stall_cycles = 0;
	int        taken = 0;
	int        hold_left = 0;
	bit        held = 1'b0;
	bit        quiet_tx = 1'b0;
	cmd_beat_t got_beat;
	cmd_beat_t want_beat;

	function void reset_sequencer();
		cfg_period = RST_SAMPLE_PERIOD;
		cfg_addr = RST_DEVICE_ADDR;
		cfg_hum_wait = RST_HUM_WAIT;
		cfg_temp_wait = RST_TEMP_WAIT;
		step = SQ_IDLE;
		last_cmd = CMD_NONE;
		ticks = '0;
		fail_flag = 1'b1;
		meas_queued = 1'b0;
		raw = '0;
		user_copy = '0;
		hum = '0;
		temp = '0;
	endfunction

	function void set_register(input logic [1:0] idx, input logic [7:0] val);
		case (idx)
			REG_SAMPLE_PERIOD: cfg_period = val;
			REG_DEVICE_ADDR:   cfg_addr = val[6:0];
			REG_HUM_WAIT:      cfg_hum_wait = val;
			REG_TEMP_WAIT:     cfg_temp_wait = val;
			default:           cfg_period = cfg_period;
		endcase
	endfunction

	function void issue(input logic [2:0] c, input logic [7:0] t, input logic [7:0] m,
			input seq_step_e nx);
		o_cmd = c;
		o_tx = t;
		o_ms = m;
		last_cmd = c;
		step = nx;
	endfunction

	function logic [7:0] addr_byte(input logic rw);
		return {cfg_addr, rw};
	endfunction

	function logic [10:0] hum_tenths(input logic [15:0] w);
		logic [31:0] q;
		q = ({16'd0, w & 16'hfffc} * 32'd125) >> 16;
		return (q >= 6) ? 11'((q - 6) * 10) : 11'd0;
	endfunction

	function logic signed [11:0] temp_tenths(input logic [15:0] w);
		longint v;
		longint n;
		v = longint'(w & 16'hfffc);
		n = v * 17572 - longint'(4685) * 65536;
		return 12'(n / 655360);
	endfunction

	function void close_sequence();
		if (meas_queued) begin
			meas_queued = 1'b0;
			issue(CMD_START, 8'd0, 8'd0, MS_START1);
		end else begin
			issue(CMD_NONE, 8'd0, 8'd0, SQ_IDLE);
		end
	endfunction

	function void bus_nack();
		fail_flag = 1'b1;
		if (step < SR_START) begin
			close_sequence();
		end else if (step < MS_START1) begin
			issue(CMD_WAIT, 8'd0, WAIT_RST2_MS, SR_WAIT100);
		end else begin
			hum = '0;
			temp = '0;
			close_sequence();
		end
	endfunction

	function void bus_done(input logic ack, input logic [7:0] rx);
		if (last_cmd == CMD_WRITE && !ack) begin
			bus_nack();
			return;
		end
		case (step)
			IN_START1:        issue(CMD_WRITE, addr_byte(1'b0), 8'd0, IN_ADDR_WR1);
			IN_ADDR_WR1:      issue(CMD_WRITE, SNS_READ_USER, 8'd0, IN_READ_REG_CMD);
			IN_READ_REG_CMD:  issue(CMD_START, 8'd0, 8'd0, IN_START2);
			IN_START2:        issue(CMD_WRITE, addr_byte(1'b1), 8'd0, IN_ADDR_RD);
			IN_ADDR_RD:       issue(CMD_READ_NACK, 8'd0, 8'd0, IN_READ);
			IN_READ: begin
				user_copy = rx;
				issue(CMD_START, 8'd0, 8'd0, IN_START3);
			end
			IN_START3:        issue(CMD_WRITE, addr_byte(1'b0), 8'd0, IN_ADDR_WR2);
			IN_ADDR_WR2:      issue(CMD_WRITE, SNS_WRITE_USER, 8'd0, IN_WRITE_REG_CMD);
			IN_WRITE_REG_CMD: issue(CMD_WRITE, (user_copy & USER_KEEP_MASK) | USER_SET_BITS,
					8'd0, IN_VALUE);
			IN_VALUE:         issue(CMD_STOP, 8'd0, 8'd0, IN_STOP);
			IN_STOP: begin
				fail_flag = 1'b0;
				issue(CMD_WAIT, 8'd0, WAIT_INIT_MS, IN_WAIT);
			end
			IN_WAIT:          issue(CMD_START, 8'd0, 8'd0, SR_START);
			SR_START:         issue(CMD_WRITE, addr_byte(1'b0), 8'd0, SR_ADDR_WR);
			SR_ADDR_WR:       issue(CMD_WRITE, SNS_SOFT_RESET, 8'd0, SR_CMD);
			SR_CMD:           issue(CMD_STOP, 8'd0, 8'd0, SR_STOP);
			SR_STOP:          issue(CMD_WAIT, 8'd0, WAIT_RST1_MS, SR_WAIT15);
			SR_WAIT15: begin
				fail_flag = 1'b0;
				issue(CMD_WAIT, 8'd0, WAIT_RST2_MS, SR_WAIT100);
			end
			SR_WAIT100:       issue(CMD_START, 8'd0, 8'd0, MS_START1);
			MS_START1:        issue(CMD_WRITE, addr_byte(1'b0), 8'd0, MS_ADDR_WR1);
			MS_ADDR_WR1:      issue(CMD_WRITE, SNS_HUM_MEAS, 8'd0, MS_HUM_CMD);
			MS_HUM_CMD:       issue(CMD_START, 8'd0, 8'd0, MS_START2);
			MS_START2:        issue(CMD_WRITE, addr_byte(1'b1), 8'd0, MS_ADDR_RD1);
			MS_ADDR_RD1:      issue(CMD_WAIT, 8'd0, cfg_hum_wait, MS_WAIT_HUM);
			MS_WAIT_HUM:      issue(CMD_READ_ACK, 8'd0, 8'd0, MS_RD_HUM1);
			MS_RD_HUM1: begin
				raw = {rx, 8'd0};
				issue(CMD_READ_NACK, 8'd0, 8'd0, MS_RD_HUM2);
			end
			MS_RD_HUM2: begin
				raw = raw | {8'd0, rx};
				issue(CMD_STOP, 8'd0, 8'd0, MS_STOP_HUM);
			end
			MS_STOP_HUM: begin
				hum = hum_tenths(raw);
				issue(CMD_WAIT, 8'd0, WAIT_GAP_MS, MS_GAP);
			end
			MS_GAP:           issue(CMD_START, 8'd0, 8'd0, MS_START3);
			MS_START3:        issue(CMD_WRITE, addr_byte(1'b0), 8'd0, MS_ADDR_WR2);
			MS_ADDR_WR2:      issue(CMD_WRITE, SNS_TEMP_MEAS, 8'd0, MS_TEMP_CMD);
			MS_TEMP_CMD:      issue(CMD_START, 8'd0, 8'd0, MS_START4);
			MS_START4:        issue(CMD_WRITE, addr_byte(1'b1), 8'd0, MS_ADDR_RD2);
			MS_ADDR_RD2:      issue(CMD_WAIT, 8'd0, cfg_temp_wait, MS_WAIT_TEMP);
			MS_WAIT_TEMP:     issue(CMD_READ_ACK, 8'd0, 8'd0, MS_RD_TEMP1);
			MS_RD_TEMP1: begin
				raw = {rx, 8'd0};
				issue(CMD_READ_NACK, 8'd0, 8'd0, MS_RD_TEMP2);
			end
			MS_RD_TEMP2: begin
				raw = raw | {8'd0, rx};
				issue(CMD_STOP, 8'd0, 8'd0, MS_STOP_TEMP);
			end
			MS_STOP_TEMP: begin
				temp = temp_tenths(raw);
				fail_flag = 1'b0;
				o_fresh = 1'b1;
				close_sequence();
			end
			default:          issue(CMD_NONE, 8'd0, 8'd0, SQ_IDLE);
		endcase
	endfunction

	function void sample_tick();
		if (step != SQ_IDLE)
			return;
		if (fail_flag) begin
			// init runs first; its own tick counts toward the period
			fail_flag = 1'b0;
			ticks = 8'd1;
			meas_queued = 1'b0;
			if (ticks >= cfg_period) begin
				ticks = '0;
				meas_queued = 1'b1;
			end
			issue(CMD_START, 8'd0, 8'd0, IN_START1);
		end else begin
			ticks = ticks + 8'd1;
			if (ticks >= cfg_period) begin
				ticks = '0;
				issue(CMD_START, 8'd0, 8'd0, MS_START1);
			end
		end
	endfunction

	function cmd_beat_t advance_sequencer(input logic op, input logic ack, input logic [7:0] rx);
		cmd_beat_t b;
		o_cmd = CMD_NONE;
		o_tx = '0;
		o_ms = '0;
		o_fresh = 1'b0;
		if (op) begin
			if (step != SQ_IDLE)
				bus_done(ack, rx);
		end else begin
			sample_tick();
		end
		b.cmd = o_cmd;
		b.tx = o_tx;
		b.ms = o_ms;
		b.hum = hum;
		b.temp = temp;
		b.fresh = o_fresh;
		b.failed = fail_flag;
		return b;
	endfunction

	// mostly answers the command in flight, with some noise and some nacks
	function void pick_item(output logic op, output logic ack, output logic [7:0] rx);
		int r;
		r = $urandom_range(0, 99);
		if (step == SQ_IDLE)
			op = (r < 8);
		else
			op = (r >= 5);
		ack = 1'($urandom_range(0, 1));
		if (op && step != SQ_IDLE && last_cmd == CMD_WRITE)
			ack = ($urandom_range(0, 99) >= 4);
		case ($urandom_range(0, 7))
			0:       rx = 8'h00;
			1:       rx = 8'hff;
			default: rx = 8'($urandom_range(0, 255));
		endcase
	endfunction

	function string beat_str(input cmd_beat_t b);
		return $sformatf("cmd %0d tx %h ms %0d hum %0d temp %0d new %0b fail %0b",
			b.cmd, b.tx, b.ms, b.hum, b.temp, b.fresh, b.failed);
	endfunction

	function void flag_mismatch(input string what, input cmd_beat_t want, input cmd_beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %s, got %s", $realtime, what, beat_str(want),
				beat_str(got));
	endfunction

	task automatic send_beat(input logic op, input logic ack, input logic [7:0] rx,
			output cmd_beat_t want);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= TDATA_IN_W'({rx, ack});
		do @(posedge clk); while (!s_tready);
		want = advance_sequencer(op, ack, rx);
	endtask

	task automatic sender_gap();
		if (!quiet_tx && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		set_register(idx, val);
	endtask

	dir_row_t dir_rows [0:27] = '{
		'{1'b1, 1'b1, 8'h5a, 1'b1, CMD_NONE,      8'h00,          8'd0},           // completion while idle
		'{1'b0, 1'b0, 8'h00, 1'b1, CMD_START,     8'h00,          8'd0},           // init tick
		'{1'b0, 1'b1, 8'hff, 1'b1, CMD_NONE,      8'h00,          8'd0},           // tick while busy
		'{1'b1, 1'b0, 8'hff, 1'b1, CMD_WRITE,     8'h80,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     SNS_READ_USER,  8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_START,     8'h00,          8'd0},
		'{1'b1, 1'b0, 8'h33, 1'b1, CMD_WRITE,     8'h81,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_READ_NACK, 8'h00,          8'd0},
		'{1'b1, 1'b0, 8'hff, 1'b1, CMD_START,     8'h00,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     8'h80,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     SNS_WRITE_USER, 8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     8'h3a,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_STOP,      8'h00,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WAIT,      8'h00,          WAIT_INIT_MS},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_START,     8'h00,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     8'h80,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     SNS_SOFT_RESET, 8'd0},
		'{1'b1, 1'b0, 8'h00, 1'b1, CMD_WAIT,      8'h00,          WAIT_RST2_MS},   // nack on soft reset
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_START,     8'h00,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     8'h80,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     SNS_HUM_MEAS,   8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_START,     8'h00,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WRITE,     8'h81,          8'd0},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_WAIT,      8'h00,          RST_HUM_WAIT},
		'{1'b1, 1'b1, 8'h00, 1'b1, CMD_READ_ACK,  8'h00,          8'd0},
		'{1'b1, 1'b1, 8'hff, 1'b0, CMD_NONE,      8'h00,          8'd0},           // top humidity
		'{1'b1, 1'b1, 8'hff, 1'b0, CMD_NONE,      8'h00,          8'd0},
		'{1'b1, 1'b0, 8'h00, 1'b0, CMD_NONE,      8'h00,          8'd0}
	};

	initial begin
		cmd_beat_t  want;
		logic       op;
		logic       ack;
		logic [7:0] rx;
		logic [7:0] p;
		logic [6:0] a;
		logic [7:0] hw;
		logic [7:0] tw;
		bit         noise;
		int         n;
		int         len;
		reset_sequencer();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].op, dir_rows[i].ack, dir_rows[i].rx, want);
			if (dir_rows[i].typed) begin
				want.cmd = dir_rows[i].cmd;
				want.tx = dir_rows[i].tx;
				want.ms = dir_rows[i].ms;
			end
			cmd_beats_due.push_back(want);
			sender_gap();
		end
		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) begin
				s_tvalid <= 1'b0;
				while (cmd_beats_due.size() != 0) @(posedge clk);
				repeat (3) @(posedge clk);
				case (ph)
					1: begin p = 8'd1;   a = 7'd127;  hw = 8'd0;   tw = 8'd255; end
					2: begin p = 8'd0;   a = 7'd0;    hw = 8'd255; tw = 8'd0;   end
					3: begin p = 8'd2;   a = 7'h55;   hw = 8'd1;   tw = 8'd254; end
					4: begin p = 8'd255; a = 7'h2a;   hw = 8'($urandom_range(0, 255));
						tw = 8'($urandom_range(0, 255)); end
					default: begin
						p = 8'($urandom_range(0, 6));
						a = 7'($urandom_range(0, 127));
						hw = 8'($urandom_range(0, 255));
						tw = 8'($urandom_range(0, 255));
					end
				endcase
				write_reg(REG_SAMPLE_PERIOD, p);
				write_reg(REG_DEVICE_ADDR, {1'b0, a});
				write_reg(REG_HUM_WAIT, hw);
				write_reg(REG_TEMP_WAIT, tw);
				cfg_valid <= 1'b0;
			end
			quiet_tx = (ph == 3);
			len = (ph == 0) ? 70 : (ph == 4) ? 40 : 85;
			n = 0;
			while (n < len) begin
				pick_item(op, ack, rx);
				noise = op ? (step == SQ_IDLE) : (step != SQ_IDLE);
				send_beat(op, ack, rx, want);
				cmd_beats_due.push_back(want);
				if (!noise)
					n++;
				sender_gap();
			end
		end
		s_tvalid <= 1'b0;
		while (cmd_beats_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stalls, one long hold-off, a quiet window
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (taken >= HOLD_AT && !held) begin
			held <= 1'b1;
			hold_left <= HOLD_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (taken >= 350 && taken < 450) || ($urandom_range(0, 99) >= 7);
		end
		if (m_tvalid && m_tready)
			taken <= taken + 1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat.cmd = m_tdata[2:0];
			got_beat.tx = m_tdata[10:3];
			got_beat.ms = m_tdata[18:11];
			got_beat.hum = m_tdata[29:19];
			got_beat.temp = m_tdata[41:30];
			got_beat.fresh = m_tdata[42];
			got_beat.failed = m_tdata[43];
			if (cmd_beats_due.size() == 0) begin
				flag_mismatch("unexpected beat", got_beat, got_beat);
			end else begin
				want_beat = cmd_beats_due.pop_front();
				if (got_beat.cmd !== want_beat.cmd || got_beat.tx !== want_beat.tx ||
						got_beat.ms !== want_beat.ms || got_beat.hum !== want_beat.hum ||
						got_beat.temp !== want_beat.temp || got_beat.fresh !== want_beat.fresh ||
						got_beat.failed !== want_beat.failed)
					flag_mismatch("mismatch", want_beat, got_beat);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
